// File: hw/rtl/pmpe_pkg.sv
package pmpe_pkg;

  // Field widths
  localparam int THETA_W = 16;
  localparam int CFG_W   = 16;
  localparam int H_W     = 17;
  localparam int VISC_W  = 16;
  localparam int WELL_W  = 17;
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INV_EPSILON = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VISC_WATER  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VISC_FERRO  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSCEPT_MAX = 8'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] INV_EPSILON_RST = 16'd256;
  localparam logic [CFG_W-1:0] VISC_WATER_RST  = 16'd4096;
  localparam logic [CFG_W-1:0] VISC_FERRO_RST  = 16'd8192;
  localparam logic [CFG_W-1:0] SUSCEPT_MAX_RST = 16'd2048;

  // Sigmoid table geometry. The table spans x in [0, 30] (Q.20); the depth
  // is a power of two so that one table step is 15 << STEP_SHIFT.
  localparam int SIG_TABLE_DEPTH = 256;
  localparam int TAB_AW     = $clog2(SIG_TABLE_DEPTH);
  localparam int IDX_W      = $clog2(SIG_TABLE_DEPTH + 1);
  localparam int XLIM_INT   = 30 << 20;
  localparam logic [63:0] XLIM_Q20 = 64'(XLIM_INT);
  localparam int MAG_W      = $clog2(XLIM_INT + 1);
  localparam int STEP_SHIFT = 21 - TAB_AW;
  localparam int M1_W       = MAG_W - STEP_SHIFT;
  localparam int MP_W       = STEP_SHIFT + 4;
  localparam int PROD_W     = H_W + MP_W;
  localparam int V_W        = PROD_W - STEP_SHIFT;
  localparam int Q2_W       = V_W - 3;
  localparam int X_W        = 33;

  // Reciprocal of 15: floor(v * RECIP15 >> RECIP15_SHIFT) is v/15 or one less
  localparam int RECIP15       = 69905;
  localparam int RECIP15_W     = 17;
  localparam int RECIP15_SHIFT = 20;

  localparam logic [H_W-1:0] H_ONE = 17'd65536;
  localparam int ONE_Q12 = 4096;

  // Pipeline depth from input transfer to result register
  localparam int PIPE_DEPTH = 7;

  typedef logic signed [THETA_W-1:0] theta_t;
  typedef logic [H_W-1:0] sig_val_t;
  typedef sig_val_t sig_tab_t [SIG_TABLE_DEPTH];

  typedef struct packed {
    logic [CFG_W-1:0] inv_epsilon;
    logic [CFG_W-1:0] visc_water;
    logic [CFG_W-1:0] visc_ferro;
    logic [CFG_W-1:0] suscept_max;
  } cfg_t;

  // Shift-subtract quotient, used only to build the sigmoid tables
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // H(x) = 1/(1+exp(-x)) for x in Q.20, result in Q0.16
  function automatic logic [63:0] sigmoid_point(input logic [63:0] xq);
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] g;
    logic [63:0] den;
    y    = xq << 5;
    sum  = 64'd1 << 31;
    term = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      term = div_u64((term * y) >> 31, 64'(k));
      sum  = sum + term;
    end
    g = div_u64(64'd1 << 62, sum);
    for (int k = 0; k < 6; k++) begin
      g = (g * g) >> 31;
    end
    den = (64'd1 << 31) + g;
    return div_u64((64'd1 << 47) + (den >> 1), den);
  endfunction

  // Table of H at sample points off .. off+DEPTH-1
  function automatic sig_tab_t build_sig_tab(input int off);
    sig_tab_t tab;
    logic [63:0] xi;
    for (int i = 0; i < SIG_TABLE_DEPTH; i++) begin
      xi = div_u64(XLIM_Q20 * 64'(i + off), 64'(SIG_TABLE_DEPTH));
      tab[i] = H_W'(sigmoid_point(xi));
    end
    return tab;
  endfunction

  // Lower and upper interpolation points of each table segment
  localparam sig_tab_t SIG_LO_TAB = build_sig_tab(0);
  localparam sig_tab_t SIG_HI_TAB = build_sig_tab(1);

endpackage

// File: hw/rtl/pmpe_ifs.sv
interface pmpe_theta_if;
  logic valid;
  logic ready;
  logic signed [pmpe_pkg::THETA_W-1:0] theta;
  modport source (output valid, output theta, input ready);
  modport sink (input valid, input theta, output ready);
endinterface

interface pmpe_result_if;
  logic valid;
  logic ready;
  logic [pmpe_pkg::H_W-1:0] smooth_step;
  logic [pmpe_pkg::VISC_W-1:0] visc_out;
  logic [pmpe_pkg::VISC_W-1:0] suscept_out;
  logic signed [pmpe_pkg::WELL_W-1:0] well_slope;
  modport source (output valid, output smooth_step, output visc_out, output suscept_out,
                  output well_slope, input ready);
  modport sink (input valid, input smooth_step, input visc_out, input suscept_out,
                input well_slope, output ready);
endinterface

interface pmpe_cfg_if;
  logic valid;
  logic ready;
  logic [pmpe_pkg::CFG_IDX_W-1:0] index;
  logic [pmpe_pkg::CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/pmpe_cfg_regs.sv
module pmpe_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  pmpe_cfg_if.sink         cfg_chan,
  output pmpe_pkg::cfg_t   cfg_o
);

  pmpe_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_chan.ready = 1'b1;

  // Decode a register write; unknown indexes drop the transfer
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        pmpe_pkg::CFG_INV_EPSILON: cfg_d.inv_epsilon = cfg_chan.data;
        pmpe_pkg::CFG_VISC_WATER:  cfg_d.visc_water  = cfg_chan.data;
        pmpe_pkg::CFG_VISC_FERRO:  cfg_d.visc_ferro  = cfg_chan.data;
        pmpe_pkg::CFG_SUSCEPT_MAX: cfg_d.suscept_max = cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_epsilon <= pmpe_pkg::INV_EPSILON_RST;
      cfg_q.visc_water  <= pmpe_pkg::VISC_WATER_RST;
      cfg_q.visc_ferro  <= pmpe_pkg::VISC_FERRO_RST;
      cfg_q.suscept_max <= pmpe_pkg::SUSCEPT_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/pmpe_sigmoid.sv
module pmpe_sigmoid (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [pmpe_pkg::THETA_W-1:0] theta_i,
  input  logic [pmpe_pkg::CFG_W-1:0]     inv_eps_i,
  output logic [pmpe_pkg::H_W-1:0]       smooth_step_o
);

  localparam int HW  = pmpe_pkg::H_W;
  localparam int XW  = pmpe_pkg::X_W;
  localparam int MW  = pmpe_pkg::MAG_W;
  localparam int SS  = pmpe_pkg::STEP_SHIFT;
  localparam int M1W = pmpe_pkg::M1_W;
  localparam int IW  = pmpe_pkg::IDX_W;
  localparam int AW  = pmpe_pkg::TAB_AW;
  localparam int MPW = pmpe_pkg::MP_W;
  localparam int PW  = pmpe_pkg::PROD_W;
  localparam int VW  = pmpe_pkg::V_W;
  localparam int QW  = pmpe_pkg::Q2_W;
  localparam int RW  = pmpe_pkg::RECIP15_W;
  localparam int RS  = pmpe_pkg::RECIP15_SHIFT;

  // Stage 1: x = theta * inv_epsilon in Q.20
  logic signed [XW-1:0] x_d, x_q;
  assign x_d = theta_i * $signed({1'b0, inv_eps_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
    end
  end

  // Stage 2: magnitude, end detection, coarse segment estimate
  logic [XW-1:0] mag_full;
  logic [MW-1:0] mag2;
  logic          over2;
  logic [M1W+RW-1:0] qprod2;
  logic          neg_q2, sat_hi_q2, sat_lo_q2;
  logic [M1W-1:0] m1_q2;
  logic [SS-1:0]  low_q2;
  logic [IW-1:0]  qest_q2;

  always_comb begin
    mag_full = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
    over2    = mag_full > XW'(pmpe_pkg::XLIM_INT);
    mag2     = mag_full[MW-1:0];
    qprod2   = (M1W+RW)'(mag2[MW-1:SS]) * (M1W+RW)'(pmpe_pkg::RECIP15);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q2    <= x_q[XW-1];
      sat_hi_q2 <= over2 && !x_q[XW-1];
      sat_lo_q2 <= over2 && x_q[XW-1];
      m1_q2     <= mag2[MW-1:SS];
      low_q2    <= mag2[SS-1:0];
      qest_q2   <= qprod2[RS +: IW];
    end
  end

  // Stage 3: fix the segment index, fetch both table points
  logic [M1W-1:0] rem3;
  logic [IW-1:0]  idx3;
  logic [3:0]     rfix3;
  logic [HW-1:0]  lo3, hi3;
  logic           neg_q3, sat_hi_q3, sat_lo_q3;
  logic [HW-1:0]  lo_q3, hi_q3;
  logic [MPW-1:0] mp_q3;

  always_comb begin
    rem3 = m1_q2 - ((M1W'(qest_q2) << 4) - M1W'(qest_q2));
    if (rem3 >= M1W'(15)) begin
      idx3  = qest_q2 + IW'(1);
      rfix3 = 4'(rem3 - M1W'(15));
    end else begin
      idx3  = qest_q2;
      rfix3 = 4'(rem3);
    end
    // The upper end point itself has no segment above it
    if (idx3 == IW'(pmpe_pkg::SIG_TABLE_DEPTH)) begin
      lo3 = pmpe_pkg::SIG_HI_TAB[pmpe_pkg::SIG_TABLE_DEPTH-1];
    end else begin
      lo3 = pmpe_pkg::SIG_LO_TAB[idx3[AW-1:0]];
    end
    hi3 = pmpe_pkg::SIG_HI_TAB[idx3[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q3    <= neg_q2;
      sat_hi_q3 <= sat_hi_q2;
      sat_lo_q3 <= sat_lo_q2;
      lo_q3     <= lo3;
      hi_q3     <= hi3;
      mp_q3     <= {rfix3, low_q2};
    end
  end

  // Stage 4: slope magnitude times offset into the segment
  logic signed [HW:0] diff4;
  logic [HW-1:0]      dmag4;
  logic               neg_q4, sat_hi_q4, sat_lo_q4, dneg_q4;
  logic [HW-1:0]      lo_q4;
  logic [PW-1:0]      prod_q4;

  always_comb begin
    diff4 = $signed({1'b0, hi_q3}) - $signed({1'b0, lo_q3});
    dmag4 = diff4[HW] ? HW'(-diff4) : HW'(diff4);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q4    <= neg_q3;
      sat_hi_q4 <= sat_hi_q3;
      sat_lo_q4 <= sat_lo_q3;
      dneg_q4   <= diff4[HW];
      lo_q4     <= lo_q3;
      prod_q4   <= PW'(dmag4) * PW'(mp_q3);
    end
  end

  // Stage 5: divide by the step, power of two part and reciprocal of 15
  logic [VW-1:0]    v5;
  logic [VW+RW-1:0] q2prod5;
  logic             neg_q5, sat_hi_q5, sat_lo_q5, dneg_q5;
  logic [HW-1:0]    lo_q5;
  logic [VW-1:0]    v_q5;
  logic [QW-1:0]    q_q5;

  always_comb begin
    v5      = prod_q4[PW-1:SS];
    q2prod5 = (VW+RW)'(v5) * (VW+RW)'(pmpe_pkg::RECIP15);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q5    <= neg_q4;
      sat_hi_q5 <= sat_hi_q4;
      sat_lo_q5 <= sat_lo_q4;
      dneg_q5   <= dneg_q4;
      lo_q5     <= lo_q4;
      v_q5      <= v5;
      q_q5      <= q2prod5[RS +: QW];
    end
  end

  // Stage 6: correct quotient, interpolate, clamp, mirror and saturate
  logic [VW-1:0]        rem6;
  logic [QW-1:0]        frac6;
  logic signed [QW+1:0] hs6;
  logic [HW-1:0]        hc6;
  logic [HW-1:0]        h_d, h_q;

  always_comb begin
    rem6  = v_q5 - ((VW'(q_q5) << 4) - VW'(q_q5));
    frac6 = (rem6 >= VW'(15)) ? q_q5 + QW'(1) : q_q5;
    if (dneg_q5) begin
      hs6 = $signed((QW+2)'(lo_q5)) - $signed((QW+2)'(frac6));
    end else begin
      hs6 = $signed((QW+2)'(lo_q5)) + $signed((QW+2)'(frac6));
    end
    if (hs6 < 0) begin
      hc6 = '0;
    end else if (hs6 > $signed((QW+2)'(pmpe_pkg::H_ONE))) begin
      hc6 = pmpe_pkg::H_ONE;
    end else begin
      hc6 = hs6[HW-1:0];
    end
    priority if (sat_hi_q5) begin
      h_d = pmpe_pkg::H_ONE;
    end else if (sat_lo_q5) begin
      h_d = '0;
    end else if (neg_q5) begin
      h_d = pmpe_pkg::H_ONE - hc6;
    end else begin
      h_d = hc6;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q <= h_d;
    end
  end

  assign smooth_step_o = h_q;

endmodule

// File: hw/rtl/pmpe_well.sv
module pmpe_well (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [pmpe_pkg::THETA_W-1:0] theta_i,
  output logic signed [pmpe_pkg::WELL_W-1:0]  well_slope_o
);

  localparam int TW = pmpe_pkg::THETA_W;
  localparam int WW = pmpe_pkg::WELL_W;
  localparam int DELAY = 3;

  typedef enum logic [1:0] {
    BAND_MID,
    BAND_LOW,
    BAND_HIGH
  } well_band_e;

  // Stage 1: classify theta, square the magnitude, form the linear branches
  well_band_e         band1;
  logic [TW-1:0]      amag1;
  logic signed [WW-1:0] outer1;
  well_band_e         band_q1, band_q2;
  logic signed [TW-1:0] t_q1, t_q2;
  logic [11:0]        a_q1;
  logic [23:0]        a2_q1;
  logic signed [WW-1:0] outer_q1, outer_q2;
  logic [35:0]        a3_q2;

  always_comb begin
    amag1 = theta_i[TW-1] ? TW'(-theta_i) : TW'(theta_i);
    if (theta_i <= -TW'(pmpe_pkg::ONE_Q12)) begin
      band1  = BAND_LOW;
      outer1 = (WW'(theta_i) + WW'(pmpe_pkg::ONE_Q12)) <<< 1;
    end else if (theta_i >= TW'(pmpe_pkg::ONE_Q12)) begin
      band1  = BAND_HIGH;
      outer1 = (WW'(theta_i) - WW'(pmpe_pkg::ONE_Q12)) <<< 1;
    end else begin
      band1  = BAND_MID;
      outer1 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      band_q1  <= band1;
      t_q1     <= theta_i;
      a_q1     <= amag1[11:0];
      a2_q1    <= 24'(amag1[11:0]) * 24'(amag1[11:0]);
      outer_q1 <= outer1;
    end
  end

  // Stage 2: cube
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      band_q2  <= band_q1;
      t_q2     <= t_q1;
      outer_q2 <= outer_q1;
      a3_q2    <= 36'(a2_q1) * 36'(a_q1);
    end
  end

  // Stage 3: round the cube to Q.12 and select the branch
  logic [36:0]          a3r3;
  logic signed [WW-1:0] c3;
  logic signed [WW-1:0] f3;
  logic signed [WW-1:0] f_q3;

  always_comb begin
    a3r3 = 37'(a3_q2) + 37'(24'h80_0000);
    c3   = $signed(WW'(a3r3[36:24]));
    if (t_q2[TW-1]) begin
      c3 = -c3;
    end
    unique case (band_q2)
      BAND_LOW:  f3 = outer_q2;
      BAND_HIGH: f3 = outer_q2;
      BAND_MID:  f3 = c3 - WW'(t_q2);
      default:   f3 = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q3 <= f3;
    end
  end

  // Stages 4 to 6: align with the sigmoid path
  logic signed [WW-1:0] dly_q [DELAY];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= f_q3;
      for (int i = 1; i < DELAY; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign well_slope_o = dly_q[DELAY-1];

endmodule

// File: hw/rtl/pmpe_mix.sv
module pmpe_mix (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  pmpe_pkg::cfg_t                     cfg_i,
  input  logic [pmpe_pkg::H_W-1:0]           smooth_step_i,
  input  logic signed [pmpe_pkg::WELL_W-1:0] well_slope_i,
  output logic [pmpe_pkg::H_W-1:0]           smooth_step_o,
  output logic [pmpe_pkg::VISC_W-1:0]        visc_out_o,
  output logic [pmpe_pkg::VISC_W-1:0]        suscept_out_o,
  output logic signed [pmpe_pkg::WELL_W-1:0] well_slope_o
);

  localparam int HW = pmpe_pkg::H_W;
  localparam int OW = pmpe_pkg::VISC_W;

  logic signed [17:0] dv;
  logic signed [35:0] vprod;
  logic signed [36:0] vsum;
  logic [OW-1:0]      visc_d, visc_q;
  logic [32:0]        sprod;
  logic [33:0]        ssum;
  logic [OW-1:0]      sus_d, sus_q;
  logic [HW-1:0]      h_q;
  logic signed [pmpe_pkg::WELL_W-1:0] well_q;

  // Viscosity as water + (ferro - water) * H, rounded, with saturation
  always_comb begin
    dv    = $signed({2'b00, cfg_i.visc_ferro}) - $signed({2'b00, cfg_i.visc_water});
    vprod = dv * $signed({1'b0, smooth_step_i});
    vsum  = $signed({5'b00000, cfg_i.visc_water, 16'h0000}) + 37'(vprod) + 37'sd32768;
    visc_d = (vsum[36:32] != 5'b00000) ? {OW{1'b1}} : vsum[31:16];
  end

  // Susceptibility as chi0 * H, rounded, with saturation
  always_comb begin
    sprod = 33'(cfg_i.suscept_max) * 33'(smooth_step_i);
    ssum  = 34'(sprod) + 34'd32768;
    sus_d = (ssum[33:32] != 2'b00) ? {OW{1'b1}} : ssum[31:16];
  end

  // Hold the result while the sink stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q    <= smooth_step_i;
      visc_q <= visc_d;
      sus_q  <= sus_d;
      well_q <= well_slope_i;
    end
  end

  assign smooth_step_o = h_q;
  assign visc_out_o    = visc_q;
  assign suscept_out_o = sus_q;
  assign well_slope_o  = well_q;

endmodule

// File: hw/rtl/phase_material_property_eval_top.sv
// Phase material property evaluator.
// theta_chan takes one signed Q3.12 phase value per transfer. result_chan returns,
// per input, the smoothed step H (Q0.16, 65536 is one), the mixed viscosity and the
// susceptibility (unsigned Q4.12) and the double-well slope (signed Q4.12).
// cfg_chan writes the four 16-bit registers by index: 0 inv_epsilon (Q8.8),
// 1 visc_water, 2 visc_ferro, 3 suscept_max; other indexes are dropped. Write
// them only while no item is in flight.
// Throughput: one item per cycle while result_chan does not stall. Each input passes
// through the seven register stages of the datapath (product, segment estimate, table
// fetch, interpolation multiply, reciprocal divide, interpolate and mirror, output
// mix) before its result is valid.
// Reset clears all valid bits and loads the register reset values; the sigmoid
// table is constant logic and needs no fill.
// When result_chan stalls with a result waiting, the whole pipeline holds and
// theta_chan.ready drops; bubbles in the pipeline are not squeezed out.
module phase_material_property_eval_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pmpe_theta_if.sink  theta_chan,
  pmpe_result_if.source result_chan,
  pmpe_cfg_if.sink    cfg_chan
);

  localparam int PD = pmpe_pkg::PIPE_DEPTH;

  pmpe_pkg::cfg_t cfg;
  logic           en;
  logic [PD-1:0]  vld_d, vld_q;
  logic [pmpe_pkg::H_W-1:0] h_sig;
  logic signed [pmpe_pkg::WELL_W-1:0] well_sig;

  // Advance when the output register is empty or being taken
  assign en = !vld_q[PD-1] || result_chan.ready;
  assign theta_chan.ready = en;
  assign vld_d = {vld_q[PD-2:0], theta_chan.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign result_chan.valid = vld_q[PD-1];

  pmpe_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_chan (cfg_chan),
    .cfg_o    (cfg)
  );

  pmpe_sigmoid u_sigmoid (
    .clk_i         (clk_i),
    .en_i          (en),
    .theta_i       (theta_chan.theta),
    .inv_eps_i     (cfg.inv_epsilon),
    .smooth_step_o (h_sig)
  );

  pmpe_well u_well (
    .clk_i        (clk_i),
    .en_i         (en),
    .theta_i      (theta_chan.theta),
    .well_slope_o (well_sig)
  );

  pmpe_mix u_mix (
    .clk_i         (clk_i),
    .en_i          (en),
    .cfg_i         (cfg),
    .smooth_step_i (h_sig),
    .well_slope_i  (well_sig),
    .smooth_step_o (result_chan.smooth_step),
    .visc_out_o    (result_chan.visc_out),
    .suscept_out_o (result_chan.suscept_out),
    .well_slope_o  (result_chan.well_slope)
  );

endmodule
